>>> hdl/row_edge_peak_detector_defines.svh
// assertion macros shared by the row edge peak detector modules
// expects a clock named clk and a reset named rst in the using module
`ifndef ROW_EDGE_PEAK_DETECTOR_DEFINES_SVH
`define ROW_EDGE_PEAK_DETECTOR_DEFINES_SVH

// checked only outside reset
`define REP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define REP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rep_pkg.sv
// shared types, widths and codes of the row edge peak detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rep_pkg;
  localparam int MAX_WIDTH = 512;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int PIX_W = 8;
  localparam int COL_W = 9;
  localparam int RW_W = 10;
  localparam int RAD_W = 6;
  localparam int PCT_W = 8;
  localparam int MEAN_W = 8;
  localparam int PS_W = PIX_W + ADDR_W;
  localparam int PK_W = 11;
  localparam int SUM_W = PK_W + ADDR_W;
  localparam int PROD_W = PK_W + PCT_W;
  localparam int DIV_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DVS_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int PCT_SCALE = 100;
  // ceil(2^26 / 100): exact quotient for every product below 2^19
  localparam int PCT_SHIFT = 26;
  localparam int PCT_RECIP = 671089;
  localparam int PCT_MUL_W = PROD_W + 20;
  localparam int EDGE_MARGIN = 4;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] CFG_ROW_WIDTH = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_PERCENT = 2'd2;

  typedef struct packed {
    logic             is_read;
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] column;
  } rep_cmd_t;

  typedef struct packed {
    logic     valid;
    rep_cmd_t cmd;
  } rep_head_t;

  typedef struct packed {
    logic [CNT_W-1:0] width;
    logic [RAD_W-1:0] radius;
    logic [PCT_W-1:0] percent;
  } rep_cfg_t;
endpackage
`default_nettype wire

>>> hdl/rep_front.sv
// front end: takes commands and holds them in a two-entry queue
// depends on rep_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "row_edge_peak_detector_defines.svh"
module rep_front import rep_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire logic      req_type,
  input  wire logic [PIX_W-1:0] pixel,
  input  wire logic [COL_W-1:0] column,
  input  wire logic      pop,
  output rep_head_t      head
);
  rep_cmd_t   slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.cmd = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= '{is_read: (req_type == REQ_READ), pixel: pixel, column: column};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `REP_ASSERT(a_no_pop_empty, pop |-> count != 2'd0, "pop from empty queue")
  `REP_ASSERT_ALWAYS(a_count_max, rst || count != 2'd3, "queue count overflow")
  `REP_ASSERT(a_push_count, (push && !pop) |=> count == $past(count) + 2'd1,
    "queue count lost a transfer")
endmodule
`default_nettype wire

>>> hdl/rep_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on rep_pkg
`timescale 1ns / 1ps
`default_nettype none
module rep_div import rep_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);
  localparam int STEP_W = $clog2(DIV_W + 1);
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              run;
  logic [DVS_W:0]    trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (go) begin
      quotient <= dividend;
      rem <= '0;
      dvs <= divisor;
      steps <= STEP_W'(DIV_W);
      run <= 1'b1;
    end else if (run) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= DVS_W'(trial - {1'b0, dvs});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DVS_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/rep_back.sv
// back end: prefix sums, row finish (edges, averages, threshold, suppression), reads
// depends on rep_pkg, rep_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "row_edge_peak_detector_defines.svh"
module rep_back import rep_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  rep_cfg_t       cfg,
  input  rep_head_t      head,
  output logic           pop,
  output logic           result_valid,
  output logic [COL_W-1:0]  column_out,
  output logic [PK_W-1:0]   peak_value,
  output logic              is_feature,
  output logic [MEAN_W-1:0] mean_luma,
  output logic              row_valid
);
  typedef enum logic [4:0] {
    B_IDLE, B_READ, B_EDGE, B_EDGE_END, B_MEAN_GO, B_MEAN_W, B_AVG_GO, B_AVG_W,
    B_MUL, B_PCT_GO, B_THR, B_THR_END, B_SUP_CHK, S_RX, S_WX, S_RR, S_WR
  } state_t;
  localparam int E_W = PS_W + 3;

  state_t state;
  logic [PS_W-1:0] ps_mem [MAX_WIDTH];
  logic [PK_W-1:0] pk_mem [MAX_WIDTH];
  logic [PS_W-1:0] ps_rdata;
  logic [PK_W-1:0] pk_rdata;
  logic [ADDR_W-1:0] pk_raddr;
  logic            pk_we;
  logic [ADDR_W-1:0] pk_waddr;
  logic [PK_W-1:0] pk_wdata;

  logic [CNT_W-1:0] pix_cnt;
  logic [PS_W-1:0]  last_sum;
  logic [CNT_W-1:0] w;
  logic [CNT_W-1:0] j;
  logic             ev;
  logic [CNT_W-1:0] ej;
  logic [PS_W-1:0]  sh [8];
  logic [PS_W-1:0]  s_last;
  logic [SUM_W-1:0] sum;
  logic [ADDR_W-1:0] cnt;
  logic [PK_W-1:0]  avg;
  logic [PROD_W-1:0] prod;
  logic [PCT_MUL_W-1:0] pct_scaled;
  logic [PK_W:0]    thr;
  logic             tv;
  logic [CNT_W-1:0] ta;
  logic [CNT_W-1:0] x;
  logic [RAD_W-1:0] r;
  logic [PK_W-1:0]  v;
  logic             col_hi;

  logic             div_go;
  logic [DIV_W-1:0] div_a;
  logic [DVS_W-1:0] div_b;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  logic signed [E_W-1:0] e1;
  logic signed [E_W-1:0] e2;
  logic [E_W-1:0]   abs1;
  logic [E_W-1:0]   abs2;
  logic [PK_W-1:0]  resp;
  logic             edge_wr;
  logic             t_inner;
  logic [PK_W-1:0]  t_val;
  logic [CNT_W-1:0] push_cnt;
  logic [PS_W-1:0]  push_sum;

  rep_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  assign pop = (state == B_IDLE) && head.valid;
  assign push_cnt = pix_cnt + CNT_W'(1);
  assign push_sum = (pix_cnt == '0) ? PS_W'(head.cmd.pixel) : last_sum + PS_W'(head.cmd.pixel);

  // second differences of prefix sums, centered on column ej-4
  assign e1 = E_W'({sh[3], 1'b0}) - E_W'(sh[1]) - E_W'(sh[5]);
  assign e2 = E_W'({sh[3], 1'b0}) - E_W'(ps_rdata) - E_W'(sh[7]);
  assign abs1 = e1[E_W-1] ? E_W'(-e1) : E_W'(e1);
  assign abs2 = e2[E_W-1] ? E_W'(-e2) : E_W'(e2);
  assign resp = PK_W'(abs1 + abs2);
  assign edge_wr = ev && (ej >= CNT_W'(2 * EDGE_MARGIN));

  // divide by 100 as a reciprocal multiply
  assign pct_scaled = PCT_MUL_W'(prod) * PCT_MUL_W'(PCT_RECIP);

  assign t_inner = (ta >= CNT_W'(EDGE_MARGIN)) && (int'(ta) + EDGE_MARGIN < int'(w));
  assign t_val = (t_inner && {1'b0, pk_rdata} >= thr) ? pk_rdata : '0;

  always_comb begin
    div_go = 1'b0;
    div_a = '0;
    div_b = '0;
    case (state)
      B_MEAN_GO: begin
        div_go = 1'b1;
        div_a = DIV_W'(s_last);
        div_b = DVS_W'(w);
      end
      B_AVG_GO: begin
        div_go = (cnt != '0);
        div_a = DIV_W'(sum);
        div_b = DVS_W'(cnt);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state)
      B_THR: pk_raddr = ADDR_W'(j);
      S_RX: pk_raddr = ADDR_W'(x);
      S_RR: pk_raddr = ADDR_W'(x + CNT_W'(r));
      default: pk_raddr = ADDR_W'(head.cmd.column);
    endcase
  end

  always_comb begin
    pk_we = 1'b0;
    pk_waddr = '0;
    pk_wdata = '0;
    if (edge_wr) begin
      pk_we = 1'b1;
      pk_waddr = ADDR_W'(ej - CNT_W'(EDGE_MARGIN));
      pk_wdata = resp;
    end else if (tv) begin
      pk_we = 1'b1;
      pk_waddr = ADDR_W'(ta);
      pk_wdata = t_val;
    end else if (state == S_WR) begin
      pk_we = 1'b1;
      pk_waddr = (pk_rdata < v) ? ADDR_W'(x + CNT_W'(r)) : ADDR_W'(x);
    end
  end

  always_ff @(posedge clk) begin
    ps_rdata <= ps_mem[ADDR_W'(j)];
    pk_rdata <= pk_mem[pk_raddr];
    if (pk_we) pk_mem[pk_waddr] <= pk_wdata;
    if (pop && !head.cmd.is_read) ps_mem[ADDR_W'(pix_cnt)] <= push_sum;
  end

  // edge pass and threshold sweep datapath
  always_ff @(posedge clk) begin
    ev <= (state == B_EDGE);
    ej <= j;
    tv <= (state == B_THR);
    ta <= j;
    if (ev) begin
      sh[0] <= ps_rdata;
      for (int k = 1; k < 8; k++) sh[k] <= sh[k-1];
      if (ej == w - CNT_W'(1)) s_last <= ps_rdata;
    end
    if (state == B_IDLE) begin
      sum <= '0;
      cnt <= '0;
    end else if (edge_wr) begin
      sum <= sum + SUM_W'(resp);
      cnt <= cnt + ADDR_W'(1);
    end
    if (rst) begin
      ev <= 1'b0;
      tv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= B_IDLE;
      pix_cnt <= '0;
      mean_luma <= '0;
      row_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (head.valid) begin
            if (head.cmd.is_read) begin
              col_hi <= (int'(head.cmd.column) >= MAX_WIDTH);
              column_out <= head.cmd.column;
              state <= B_READ;
            end else begin
              last_sum <= push_sum;
              if (push_cnt >= cfg.width) begin
                pix_cnt <= '0;
                w <= cfg.width;
                j <= '0;
                state <= B_EDGE;
              end else begin
                pix_cnt <= push_cnt;
              end
            end
          end
        end
        B_READ: begin
          peak_value <= col_hi ? '0 : pk_rdata;
          is_feature <= !col_hi && (pk_rdata != '0);
          result_valid <= 1'b1;
          state <= B_IDLE;
        end
        B_EDGE: begin
          j <= j + CNT_W'(1);
          if (j == w - CNT_W'(1)) state <= B_EDGE_END;
        end
        B_EDGE_END: state <= B_MEAN_GO;
        B_MEAN_GO: state <= B_MEAN_W;
        B_MEAN_W: begin
          if (div_done) begin
            mean_luma <= div_q[MEAN_W-1:0];
            state <= B_AVG_GO;
          end
        end
        B_AVG_GO: begin
          if (cnt == '0) begin
            avg <= '0;
            state <= B_MUL;
          end else begin
            state <= B_AVG_W;
          end
        end
        B_AVG_W: begin
          if (div_done) begin
            avg <= div_q[PK_W-1:0];
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod <= PROD_W'(avg) * PROD_W'(cfg.percent);
          state <= B_PCT_GO;
        end
        B_PCT_GO: begin
          thr <= pct_scaled[PCT_SHIFT +: PK_W + 1];
          j <= '0;
          state <= B_THR;
        end
        B_THR: begin
          j <= j + CNT_W'(1);
          if (j == CNT_W'(MAX_WIDTH - 1)) state <= B_THR_END;
        end
        B_THR_END: state <= B_SUP_CHK;
        B_SUP_CHK: begin
          x <= CNT_W'(EDGE_MARGIN);
          if (cfg.radius > RAD_W'(1) && EDGE_MARGIN + int'(cfg.radius) < int'(w)) begin
            state <= S_RX;
          end else begin
            row_valid <= 1'b1;
            state <= B_IDLE;
          end
        end
        S_RX: state <= S_WX;
        S_WX: begin
          v <= pk_rdata;
          r <= RAD_W'(1);
          if (pk_rdata != '0) begin
            state <= S_RR;
          end else begin
            x <= x + CNT_W'(1);
            if (int'(x) + 1 + int'(cfg.radius) < int'(w)) begin
              state <= S_RX;
            end else begin
              row_valid <= 1'b1;
              state <= B_IDLE;
            end
          end
        end
        S_RR: state <= S_WR;
        S_WR: begin
          if (pk_rdata < v && r + RAD_W'(1) < cfg.radius) begin
            r <= r + RAD_W'(1);
            state <= S_RR;
          end else begin
            x <= x + CNT_W'(1);
            if (int'(x) + 1 + int'(cfg.radius) < int'(w)) begin
              state <= S_RX;
            end else begin
              row_valid <= 1'b1;
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `REP_ASSERT(a_pop_idle, pop |-> state == B_IDLE, "queue popped while back end busy")
  `REP_ASSERT(a_result_src, result_valid |-> $past(state) == B_READ,
    "result strobe without a read")
  `REP_ASSERT(a_one_writer, edge_wr |-> !tv && state != S_WR,
    "two writers on the peak memory")
endmodule
`default_nettype wire

>>> hdl/row_edge_peak_detector.sv
// Row edge peak detector. A command is taken on a clock edge with start high and busy low;
// busy rises only when the two-entry command queue is full. A pixel push that does not
// complete a row leaves the back end idle. The push that completes a row starts the row
// finish: one prefix-sum memory read per column for the edge pass, a serial divider for the
// row mean and the average response, a reciprocal multiply for the percent scaling, a
// threshold sweep over all 512 peak entries, and a suppression scan that reads the peak
// memory once per scanned column and once per compare. A read command leaves the queue on
// the edge after its transfer when the back end is idle and no older command waits ahead
// of it, and its result comes up on result_valid at the following edge for exactly one
// cycle; the receiver cannot stall it. Reads before the first completed row return undefined
// peaks. Write configuration only when the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module row_edge_peak_detector import rep_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              req_type,
  input  wire logic [PIX_W-1:0]  pixel,
  input  wire logic [COL_W-1:0]  column,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [RW_W-1:0]   cfg_data,
  output logic                   result_valid,
  output logic [COL_W-1:0]       column_out,
  output logic [PK_W-1:0]        peak_value,
  output logic                   is_feature,
  output logic [MEAN_W-1:0]      mean_luma,
  output logic                   row_valid
);
  logic [RW_W-1:0]  row_width;
  logic [RAD_W-1:0] suppress_radius;
  logic [PCT_W-1:0] response_percent;
  rep_cfg_t  cfg;
  rep_head_t head;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= RW_W'(320);
      suppress_radius <= RAD_W'(16);
      response_percent <= PCT_W'(180);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW_WIDTH: row_width <= cfg_data;
        CFG_RADIUS: suppress_radius <= cfg_data[RAD_W-1:0];
        CFG_PERCENT: response_percent <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // width limited to 1..MAX_WIDTH
  always_comb begin
    if (row_width == '0) cfg.width = CNT_W'(1);
    else if (int'(row_width) > MAX_WIDTH) cfg.width = CNT_W'(MAX_WIDTH);
    else cfg.width = CNT_W'(row_width);
    cfg.radius = suppress_radius;
    cfg.percent = response_percent;
  end

  rep_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .pixel(pixel), .column(column), .pop(pop), .head(head)
  );

  rep_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .pop(pop),
    .result_valid(result_valid), .column_out(column_out), .peak_value(peak_value),
    .is_feature(is_feature), .mean_luma(mean_luma), .row_valid(row_valid)
  );
endmodule
`default_nettype wire
